>>> hdl/infix_to_postfix_converter_top_macros.svh
// assertion macros for the infix-to-postfix converter
// used by the top level only; no other dependencies
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ITOP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("itop assertion failed");
`define ITOP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itop implication failed");
`else
`define ITOP_ASSERT(lbl, clk, rst, prop)
`define ITOP_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hdl/itop_pkg.sv
// shared types, character codes and classification functions
// for the infix-to-postfix converter; no dependencies
package itop_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOLR  = 8'h24;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNMATCHED = 2'd2
  } err_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] sym;
    logic       sym_valid;
    logic       last;
    logic       done;
    err_t       err;
  } result_t;

  function automatic logic is_operand(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
           c == CH_DOLR;
  endfunction

  // ranked precedence: '$' lowest, then + -, then * /
  function automatic logic [1:0] prec_rank(input logic [7:0] c);
    if (c == CH_PLUS || c == CH_MINUS) return 2'd1;
    if (c == CH_STAR || c == CH_SLASH) return 2'd2;
    return 2'd0;
  endfunction

endpackage

>>> hdl/itop_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module itop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/itop_core.sv
// sequencer for the operator stack: classifies input characters, scans
// the stack ram and produces result transactions; uses itop_pkg
module itop_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_symbol,
  input  logic                           in_end,
  input  logic                           out_free,
  output logic                           emit_valid,
  output itop_pkg::result_t              emit,
  output logic                           wr_en,
  output logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
  output logic [7:0]                     wr_data,
  output logic                           rd_en,
  output logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
  input  logic [7:0]                     rd_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {IDLE, SCAN, FIN, ERR2} state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [7:0]    cur_sym, cur_sym_next;
  logic          cur_end, cur_end_next;
  logic          pend_valid, pend_valid_next;
  logic [7:0]    pend_sym, pend_sym_next;

  logic [CW-1:0] cnt_m1, cnt_m2;
  logic          full, cur_close, pop_it, need_out;

  assign cnt_m1    = count - CW'(1);
  assign cnt_m2    = count - CW'(2);
  assign full      = count == CW'(STACK_DEPTH);
  assign cur_close = cur_sym == itop_pkg::CH_CLOSE;

  // does the entry on top of the stack leave it as an output character
  always_comb begin
    if (cur_end) begin
      pop_it = 1'b1;
    end else if (cur_close) begin
      pop_it = rd_data != itop_pkg::CH_OPEN;
    end else begin
      pop_it = rd_data != itop_pkg::CH_OPEN &&
               itop_pkg::prec_rank(cur_sym) <= itop_pkg::prec_rank(rd_data);
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    cur_sym_next    = cur_sym;
    cur_end_next    = cur_end;
    pend_valid_next = pend_valid;
    pend_sym_next   = pend_sym;
    in_ready        = 1'b0;
    emit_valid      = 1'b0;
    emit            = '0;
    wr_en           = 1'b0;
    wr_addr         = count[AW-1:0];
    wr_data         = cur_sym;
    rd_en           = 1'b0;
    rd_addr         = cnt_m1[AW-1:0];
    need_out        = 1'b0;

    unique case (state)
      IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          cur_sym_next    = in_symbol;
          cur_end_next    = in_end;
          pend_valid_next = 1'b0;
          wr_data         = in_symbol;
          if (in_end) begin
            if (count == '0) begin
              emit_valid = 1'b1;
              emit.last  = 1'b1;
              emit.done  = 1'b1;
            end else begin
              rd_en      = 1'b1;
              state_next = SCAN;
            end
          end else if (itop_pkg::is_operand(in_symbol)) begin
            emit_valid     = 1'b1;
            emit.sym       = in_symbol;
            emit.sym_valid = 1'b1;
            emit.last      = 1'b1;
          end else if (in_symbol == itop_pkg::CH_OPEN) begin
            if (full) begin
              emit_valid = 1'b1;
              emit.last  = 1'b1;
              emit.err   = itop_pkg::ERR_OVERFLOW;
            end else begin
              wr_en      = 1'b1;
              count_next = count + CW'(1);
            end
          end else if (itop_pkg::is_operator(in_symbol)) begin
            if (count == '0) begin
              wr_en      = 1'b1;
              count_next = count + CW'(1);
            end else begin
              rd_en      = 1'b1;
              state_next = SCAN;
            end
          end else if (in_symbol == itop_pkg::CH_CLOSE) begin
            if (count == '0) begin
              emit_valid = 1'b1;
              emit.last  = 1'b1;
              emit.err   = itop_pkg::ERR_UNMATCHED;
            end else begin
              rd_en      = 1'b1;
              state_next = SCAN;
            end
          end
        end
      end

      SCAN: begin
        if (pop_it) begin
          // the held character is not last, one more follows
          if (!pend_valid || out_free) begin
            emit_valid      = pend_valid;
            emit.sym        = pend_sym;
            emit.sym_valid  = 1'b1;
            pend_valid_next = 1'b1;
            pend_sym_next   = rd_data;
            count_next      = cnt_m1;
            if (count > CW'(1)) begin
              rd_en   = 1'b1;
              rd_addr = cnt_m2[AW-1:0];
            end else begin
              state_next = FIN;
            end
          end
        end else begin
          need_out = pend_valid || (!cur_close && full);
          if (!need_out || out_free) begin
            state_next      = IDLE;
            pend_valid_next = 1'b0;
            if (cur_close) begin
              // matching open parenthesis is discarded
              count_next     = cnt_m1;
              emit_valid     = pend_valid;
              emit.sym       = pend_sym;
              emit.sym_valid = 1'b1;
              emit.last      = 1'b1;
            end else if (pend_valid) begin
              emit_valid     = 1'b1;
              emit.sym       = pend_sym;
              emit.sym_valid = 1'b1;
              emit.last      = 1'b1;
              wr_en          = 1'b1;
              count_next     = count + CW'(1);
            end else if (full) begin
              emit_valid = 1'b1;
              emit.last  = 1'b1;
              emit.err   = itop_pkg::ERR_OVERFLOW;
            end else begin
              wr_en      = 1'b1;
              count_next = count + CW'(1);
            end
          end
        end
      end

      FIN: begin
        // stack drained, one character still held
        if (out_free) begin
          emit_valid      = 1'b1;
          emit.sym        = pend_sym;
          emit.sym_valid  = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = IDLE;
          if (cur_end) begin
            emit.last = 1'b1;
            emit.done = 1'b1;
          end else if (cur_close) begin
            state_next = ERR2;
          end else begin
            emit.last  = 1'b1;
            wr_en      = 1'b1;
            count_next = count + CW'(1);
          end
        end
      end

      ERR2: begin
        if (out_free) begin
          emit_valid = 1'b1;
          emit.last  = 1'b1;
          emit.err   = itop_pkg::ERR_UNMATCHED;
          state_next = IDLE;
        end
      end

      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
    end
    cur_sym  <= cur_sym_next;
    cur_end  <= cur_end_next;
    pend_sym <= pend_sym_next;
  end

endmodule

>>> hdl/infix_to_postfix_converter_top.sv
// top level of the infix-to-postfix converter: stack ram, sequencer and
// output register; uses itop_pkg, itop_ram, itop_core and the macros header
//
// usage:
//   s_axis carries one ascii character per transaction in tdata[7:0];
//   tlast set marks the end of the expression and flushes the stack
//   (the character is then ignored).
//   m_axis carries the postfix characters and status transactions;
//   tlast marks the final result caused by one input transaction.
// sequencing:
//   an operand appears in the output register in the cycle after it is taken.
//   an operator or ')' on a non-empty stack reads the top of stack from the
//   ram (registered read), then pops one entry per step and finishes with
//   a last step; ')' that drains the stack adds a step for its error
//   transaction. the end flush pops the whole stack, done set on the last
//   character, or emits done alone on an empty stack. one item at a time.
// reset: rst clears the stack count and all control state; ram contents
//   are left as they are and never read before being written.
// stall: a waiting result sits in the output register; the sequencer
//   holds its state and the ram read data until the register frees up.
`include "infix_to_postfix_converter_top_macros.svh"

module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic        s_axis_tlast,   // end_of_expression
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_symbol, [8] expression_done,
                                      // [10:9] error_code, [15:11] zero
  output logic        m_axis_tlast,   // last_of_run
  output logic        m_axis_tuser    // symbol_valid
);

  localparam int AW = $clog2(STACK_DEPTH);

  // sequencer to ram
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  // sequencer to output register
  logic              core_emit_valid;
  itop_pkg::result_t core_emit;
  logic              out_free;

  // output register
  logic              out_valid;
  itop_pkg::result_t out_r;

  itop_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  itop_core #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_symbol  (s_axis_tdata),
    .in_end     (s_axis_tlast),
    .out_free   (out_free),
    .emit_valid (core_emit_valid),
    .emit       (core_emit),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  // register is free when empty or being drained this cycle
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_emit_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (core_emit_valid) begin
      out_r <= core_emit;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_r.err, out_r.done, out_r.sym};
  assign m_axis_tlast  = out_r.last;
  assign m_axis_tuser  = out_r.sym_valid;

  // the sequencer never overwrites a result still waiting in the register
  `ITOP_ASSERT(a_no_overwrite, clk, rst, core_emit_valid |-> out_free)
  // an error transaction carries no character and ends its run
  `ITOP_ASSERT_IMPL(a_err_status_only, clk, rst,
                    core_emit_valid && core_emit.err != itop_pkg::ERR_NONE,
                    !core_emit.sym_valid && core_emit.last)
  // end of expression always closes its run
  `ITOP_ASSERT_IMPL(a_done_last, clk, rst,
                    m_axis_tvalid && m_axis_tdata[8], m_axis_tlast)
  // no input taken while a result is blocked in the register
  `ITOP_ASSERT_IMPL(a_no_take_when_blocked, clk, rst,
                    m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

>>> verif/postfix_checker.sv
// result checker for the infix-to-postfix converter: watches both stream
// channels, predicts the postfix output and compares it field by field
// depends on itop_pkg for character codes, error codes and the result struct
module postfix_checker #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  output int          fail_count,
  output int          pending
);

  logic [7:0]        op_stack [STACK_DEPTH];
  int                depth_used;
  itop_pkg::result_t postfix_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    depth_used = 0;
  end

  function automatic bit is_alnum(logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") ||
           (ch >= "0" && ch <= "9");
  endfunction

  function automatic bit is_arith(logic [7:0] ch);
    return ch == itop_pkg::CH_PLUS || ch == itop_pkg::CH_MINUS ||
           ch == itop_pkg::CH_STAR || ch == itop_pkg::CH_SLASH ||
           ch == itop_pkg::CH_DOLR;
  endfunction

  function automatic int rank(logic [7:0] ch);
    if (ch == itop_pkg::CH_PLUS || ch == itop_pkg::CH_MINUS) return 1;
    if (ch == itop_pkg::CH_STAR || ch == itop_pkg::CH_SLASH) return 2;
    return -1;
  endfunction

  function automatic void emit(logic [7:0] sym, logic sym_valid, itop_pkg::err_t err);
    itop_pkg::result_t r;
    r.sym       = sym;
    r.sym_valid = sym_valid;
    r.last      = 1'b0;
    r.done      = 1'b0;
    r.err       = err;
    postfix_q   = {postfix_q, r};
  endfunction

  function automatic void push_or_overflow(logic [7:0] ch);
    if (depth_used < STACK_DEPTH) begin
      op_stack[depth_used] = ch;
      depth_used++;
    end else begin
      emit(8'h00, 1'b0, itop_pkg::ERR_OVERFLOW);
    end
  endfunction

  // one input transaction: update the stack and queue the postfix output
  function automatic void convert_symbol(logic [7:0] ch, logic flush);
    int                queued_at_start;
    bit                matched;
    itop_pkg::result_t r;
    queued_at_start = postfix_q.size();
    matched         = 1'b0;
    if (flush) begin
      while (depth_used > 0) begin
        depth_used--;
        emit(op_stack[depth_used], 1'b1, itop_pkg::ERR_NONE);
      end
      if (postfix_q.size() == queued_at_start)
        emit(8'h00, 1'b0, itop_pkg::ERR_NONE);
    end else if (is_alnum(ch)) begin
      emit(ch, 1'b1, itop_pkg::ERR_NONE);
    end else if (ch == itop_pkg::CH_OPEN) begin
      push_or_overflow(ch);
    end else if (is_arith(ch)) begin
      while (depth_used > 0 && op_stack[depth_used-1] != itop_pkg::CH_OPEN &&
             rank(ch) <= rank(op_stack[depth_used-1])) begin
        depth_used--;
        emit(op_stack[depth_used], 1'b1, itop_pkg::ERR_NONE);
      end
      push_or_overflow(ch);
    end else if (ch == itop_pkg::CH_CLOSE) begin
      while (depth_used > 0 && !matched) begin
        depth_used--;
        if (op_stack[depth_used] == itop_pkg::CH_OPEN)
          matched = 1'b1;
        else
          emit(op_stack[depth_used], 1'b1, itop_pkg::ERR_NONE);
      end
      if (!matched)
        emit(8'h00, 1'b0, itop_pkg::ERR_UNMATCHED);
    end
    if (postfix_q.size() > queued_at_start) begin
      r      = postfix_q[postfix_q.size() - 1];
      r.last = 1'b1;
      r.done = flush;
      postfix_q[postfix_q.size() - 1] = r;
    end
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    itop_pkg::result_t want;
    if (rst) begin
      depth_used = 0;
      postfix_q.delete();
    end else begin
      // outputs first: a result never belongs to an input taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (postfix_q.size() == 0) begin
          $error("unexpected result transaction: out_symbol %0h", m_axis_tdata[7:0]);
          fail_count++;
        end else begin
          want = postfix_q.pop_front();
          check_field("out_symbol", want.sym, m_axis_tdata[7:0]);
          check_field("symbol_valid", 8'(want.sym_valid), 8'(m_axis_tuser));
          check_field("last_of_run", 8'(want.last), 8'(m_axis_tlast));
          check_field("expression_done", 8'(want.done), 8'(m_axis_tdata[8]));
          check_field("error_code", 8'(want.err), 8'(m_axis_tdata[10:9]));
          check_field("tdata padding", 8'h00, 8'(m_axis_tdata[15:11]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        convert_symbol(s_axis_tdata, s_axis_tlast);
    end
    pending = postfix_q.size();
  end

endmodule

>>> verif/tb.sv
// top of the infix-to-postfix converter testbench: clock, reset, stimulus
// and verdict; depends on itop_pkg, postfix_checker and the converter rtl
module tb;

  localparam int STACK_DEPTH = 16;
  localparam int RANDOM_ITEMS = 500;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] symbol
  logic        s_axis_tlast;   // end_of_expression
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] out_symbol, [8] expression_done,
                               // [10:9] error_code, [15:11] zero
  logic        m_axis_tlast;   // last_of_run
  logic        m_axis_tuser;   // symbol_valid

  int fail_count;
  int pending;

  // no idling at all once the run gets near its end
  bit quiet;
  // chance in percent of an idle burst before a sender transaction
  int gap_pct;
  // counts transactions that are not noise
  int sent_items;

  infix_to_postfix_converter_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // prediction and comparison live in the checker beside the block
  postfix_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) postfix_chk (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  // random letter or digit
  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'("a" + $urandom_range(0, 25));
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 4))
      0:       return itop_pkg::CH_PLUS;
      1:       return itop_pkg::CH_MINUS;
      2:       return itop_pkg::CH_STAR;
      3:       return itop_pkg::CH_SLASH;
      default: return itop_pkg::CH_DOLR;
    endcase
  endfunction

  // one sender transaction; called at a falling edge, returns at a falling edge
  task automatic send(input logic [7:0] sym, input logic eoe, input bit counted);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= eoe;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    if (counted) sent_items++;
  endtask

  // whole expression followed by the end marker, whose symbol is junk
  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++)
      send(text[i], 1'b0, 1'b1);
    send(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  // receiver side: bursts of stall and of readiness, long clean runs now and then
  initial begin
    int run_len;
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      run_len = 1;
      if (quiet) begin
        m_axis_tready <= 1'b1;
      end else begin
        case ($urandom_range(0, 5))
          0, 1: begin
            m_axis_tready <= 1'b0;
            run_len = $urandom_range(1, 10);
          end
          5: begin
            m_axis_tready <= 1'b1;
            run_len = $urandom_range(20, 60);
          end
          default: begin
            m_axis_tready <= 1'b1;
            run_len = $urandom_range(1, 10);
          end
        endcase
      end
      repeat (run_len) @(negedge clk);
    end
  end

  initial begin
    int n;
    int depth;
    int steps;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    quiet         = 1'b0;
    gap_pct       = 25;
    sent_items    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: every operand extreme and operator, nesting, '$' popping '/',
    // a ')' that pops then finds no '(', a leftover '(' in the end flush
    send_text("A+z*0-(9/Z$a)");
    send_text("a*b)");
    send_text("(a+b");
    // ignored characters, a ')' on an empty stack, end flush on an empty stack
    send(8'h00, 1'b0, 1'b0);
    send(8'hFF, 1'b0, 1'b0);
    send(" ", 1'b0, 1'b0);
    send(itop_pkg::CH_CLOSE, 1'b0, 1'b1);
    send(8'h00, 1'b1, 1'b1);

    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      quiet   = sent_items >= RANDOM_ITEMS - 60;
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      case ($urandom_range(0, 9))
        // well-formed expression with random nesting
        0, 1, 2, 3, 4, 5: begin
          n     = $urandom_range(1, 8);
          depth = 0;
          for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0) begin
              send(itop_pkg::CH_OPEN, 1'b0, 1'b1);
              depth++;
            end
            send(rand_operand(), 1'b0, 1'b1);
            while (depth > 0 && $urandom_range(0, 2) == 0) begin
              send(itop_pkg::CH_CLOSE, 1'b0, 1'b1);
              depth--;
            end
            if (k < n - 1)
              send(rand_operator(), 1'b0, 1'b1);
          end
          while (depth > 0) begin
            send(itop_pkg::CH_CLOSE, 1'b0, 1'b1);
            depth--;
          end
        end
        // deep stack, often past its capacity
        6: begin
          steps = $urandom_range(12, 20);
          for (int k = 0; k < steps; k++) begin
            if ($urandom_range(0, 1) == 0) begin
              send(itop_pkg::CH_OPEN, 1'b0, 1'b1);
            end else begin
              send(rand_operand(), 1'b0, 1'b1);
              send(rand_operator(), 1'b0, 1'b1);
            end
          end
          send(rand_operand(), 1'b0, 1'b1);
          repeat ($urandom_range(0, steps)) send(itop_pkg::CH_CLOSE, 1'b0, 1'b1);
        end
        // noise: any byte at all
        7: begin
          repeat ($urandom_range(1, 6)) send(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        // broken sequence of random tokens
        8: begin
          repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 3))
              0:       send(rand_operand(), 1'b0, 1'b1);
              1:       send(rand_operator(), 1'b0, 1'b1);
              2:       send(itop_pkg::CH_OPEN, 1'b0, 1'b1);
              default: send(itop_pkg::CH_CLOSE, 1'b0, 1'b1);
            endcase
          end
        end
        // surplus close parentheses
        default: begin
          n = $urandom_range(1, 4);
          for (int k = 0; k < n; k++) begin
            send(rand_operand(), 1'b0, 1'b1);
            if (k < n - 1)
              send(rand_operator(), 1'b0, 1'b1);
          end
          repeat ($urandom_range(1, 3)) send(itop_pkg::CH_CLOSE, 1'b0, 1'b1);
        end
      endcase
      send(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end

    // drain: every expected transaction, then a final wait before the verdict
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (2 * STACK_DEPTH + 8) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
